[sv/pfc_pkg.sv]
package pfc_pkg;

	localparam int NUM_CH = 4;

	// channel slots, lowest first
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;
	localparam int CH_A = 3;

	// configuration register indexes
	localparam logic REG_SRC_FMT = 1'b0;
	localparam logic REG_DST_FMT = 1'b1;

	// format codes as the configuration registers take them
	localparam logic [3:0] FMT_NONE     = 4'd0;   // behaves as R8G8B8
	localparam logic [3:0] FMT_R8G8B8   = 4'd1;
	localparam logic [3:0] FMT_A8R8G8B8 = 4'd2;
	localparam logic [3:0] FMT_X8R8G8B8 = 4'd3;
	localparam logic [3:0] FMT_R5G6B5   = 4'd4;
	localparam logic [3:0] FMT_R5G5B5   = 4'd5;
	localparam logic [3:0] FMT_P4       = 4'd6;
	localparam logic [3:0] FMT_P8       = 4'd7;
	localparam logic [3:0] FMT_A1R5G5B5 = 4'd8;
	localparam logic [3:0] FMT_X4R4G4B4 = 4'd9;
	localparam logic [3:0] FMT_A4R4G4B4 = 4'd10;
	localparam logic [3:0] FMT_R3G3B2   = 4'd11;
	localparam logic [3:0] FMT_R3G2B3   = 4'd12;
	localparam logic [3:0] FMT_A8       = 4'd13;
	localparam logic [3:0] FMT_A8R3G3B2 = 4'd14;
	localparam logic [3:0] FMT_A8R3G2B3 = 4'd15;

	// channel field: lsb position and width (0 = channel absent)
	typedef struct packed {
		logic [4:0] shift;
		logic [3:0] bits;
	} chan_fmt_t;

	typedef struct packed {
		logic [2:0]                 size;
		chan_fmt_t [NUM_CH-1:0]     ch;
	} fmt_t;

	// item handed from the front to the back
	typedef struct packed {
		logic [NUM_CH-1:0][7:0] v8;   // left-aligned channel values
		logic [NUM_CH-1:0]      has;  // source carries the channel
		logic                   last;
	} item_t;

	function automatic fmt_t mk_fmt(
		input logic [2:0] size,
		input logic [4:0] rs, input logic [3:0] rb,
		input logic [4:0] gs, input logic [3:0] gb,
		input logic [4:0] bs, input logic [3:0] bb,
		input logic [4:0] as_, input logic [3:0] ab
	);
		fmt_t f;
		f.size = size;
		f.ch[CH_R] = '{shift: rs, bits: rb};
		f.ch[CH_G] = '{shift: gs, bits: gb};
		f.ch[CH_B] = '{shift: bs, bits: bb};
		f.ch[CH_A] = '{shift: as_, bits: ab};
		return f;
	endfunction

	// format table; code zero behaves as R8G8B8
	function automatic fmt_t fmt_lookup(input logic [3:0] code);
		fmt_t f;
		case (code)
			FMT_A8R8G8B8: f = mk_fmt(3'd4, 5'd16, 4'd8, 5'd8, 4'd8, 5'd0, 4'd8, 5'd24, 4'd8);
			FMT_X8R8G8B8: f = mk_fmt(3'd4, 5'd16, 4'd8, 5'd8, 4'd8, 5'd0, 4'd8, 5'd0, 4'd0);
			FMT_R5G6B5:   f = mk_fmt(3'd2, 5'd11, 4'd5, 5'd5, 4'd6, 5'd0, 4'd5, 5'd0, 4'd0);
			FMT_R5G5B5:   f = mk_fmt(3'd2, 5'd10, 4'd5, 5'd5, 4'd5, 5'd0, 4'd5, 5'd0, 4'd0);
			FMT_P4,
			FMT_P8:       f = mk_fmt(3'd1, 5'd0, 4'd0, 5'd0, 4'd0, 5'd0, 4'd0, 5'd0, 4'd0);
			FMT_A1R5G5B5: f = mk_fmt(3'd2, 5'd10, 4'd5, 5'd5, 4'd5, 5'd0, 4'd5, 5'd15, 4'd1);
			FMT_X4R4G4B4: f = mk_fmt(3'd2, 5'd8, 4'd4, 5'd4, 4'd4, 5'd0, 4'd4, 5'd0, 4'd0);
			FMT_A4R4G4B4: f = mk_fmt(3'd2, 5'd8, 4'd4, 5'd4, 4'd4, 5'd0, 4'd4, 5'd12, 4'd4);
			FMT_R3G3B2:   f = mk_fmt(3'd1, 5'd5, 4'd3, 5'd2, 4'd3, 5'd0, 4'd2, 5'd0, 4'd0);
			FMT_R3G2B3:   f = mk_fmt(3'd1, 5'd5, 4'd3, 5'd3, 4'd2, 5'd0, 4'd3, 5'd0, 4'd0);
			FMT_A8:       f = mk_fmt(3'd1, 5'd0, 4'd0, 5'd0, 4'd0, 5'd0, 4'd0, 5'd0, 4'd8);
			FMT_A8R3G3B2: f = mk_fmt(3'd2, 5'd5, 4'd3, 5'd2, 4'd3, 5'd0, 4'd2, 5'd8, 4'd8);
			FMT_A8R3G2B3: f = mk_fmt(3'd2, 5'd5, 4'd3, 5'd3, 4'd2, 5'd0, 4'd3, 5'd8, 4'd8);
			default:      f = mk_fmt(3'd3, 5'd16, 4'd8, 5'd8, 4'd8, 5'd0, 4'd8, 5'd0, 4'd0);
		endcase
		return f;
	endfunction

endpackage

[sv/pfc_front.sv]
module pfc_front
	import pfc_pkg::*;
(
	input  logic [3:0]  source_format,
	input  logic [31:0] src_pixel,
	input  logic        last_pixel,
	output item_t       item
);

	fmt_t sf;

	assign sf = fmt_lookup(source_format);

	// pull each channel out and left-align it to 8 bits
	always_comb begin
		logic [7:0] fmask;
		logic [7:0] fval;
		item.last = last_pixel;
		for (int k = 0; k < NUM_CH; k++) begin
			fmask = 8'((9'd1 << sf.ch[k].bits) - 9'd1);
			fval = 8'(src_pixel >> sf.ch[k].shift) & fmask;
			item.v8[k] = fval << (4'd8 - sf.ch[k].bits);
			item.has[k] = (sf.ch[k].bits != 4'd0);
		end
	end

endmodule

[sv/pfc_queue.sv]
module pfc_queue
	import pfc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t pop_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/pfc_back.sv]
module pfc_back
	import pfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  dest_format,
	input  logic        item_valid,
	input  item_t       item,
	output logic        item_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	fmt_t        df;
	logic [31:0] dst;
	logic [31:0] bmask;
	logic        load;
	logic        m_tvalid_q;
	logic [31:0] dst_q;
	logic [2:0]  count_q;
	logic        last_q;

	assign df = fmt_lookup(dest_format);

	// start from all ones, overwrite fields the source can supply
	always_comb begin
		logic [31:0] dm;
		logic [31:0] dv;
		dst = '1;
		for (int k = 0; k < NUM_CH; k++) begin
			dm = 32'((9'd1 << df.ch[k].bits) - 9'd1) << df.ch[k].shift;
			dv = 32'(item.v8[k] >> (4'd8 - df.ch[k].bits)) << df.ch[k].shift;
			if (df.ch[k].bits != 4'd0 && item.has[k]) begin
				dst = (dst & ~dm) | (dv & dm);
			end
		end
	end

	always_comb begin
		case (df.size)
			3'd1:    bmask = 32'h0000_00ff;
			3'd2:    bmask = 32'h0000_ffff;
			3'd3:    bmask = 32'h00ff_ffff;
			default: bmask = 32'hffff_ffff;
		endcase
	end

	assign load     = item_valid && (!m_tvalid_q || m_tready);
	assign item_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dst_q   <= dst & bmask;
			count_q <= df.size;
			last_q  <= item.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, count_q, dst_q};
	assign m_tlast  = last_q;

endmodule

[sv/pixel_format_converter.sv]
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata[31:0] src_pixel, tlast last_pixel
// m_*       out  m_tvalid/m_tready   tdata[31:0] dst_pixel, [34:32] dst_byte_count,
//                                    tlast last_out
// apb       in   psel/penable        0x0 source_format, 0x4 dest_format
//
// One pixel per clock sustained while m_tready stays high; each pixel passes a queue
// slot, then the output register. The rate is set by the single output register drain.
// Reset (arst_n low) empties the two-deep queue, drops the output and sets
// both formats to R8G8B8. s_tready falls only when the queue is full; m_tready
// held low during a steady stream fills it.
module pixel_format_converter
	import pfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] src_pixel
	input  logic        s_tlast,
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] dst_pixel, [34:32] dst_byte_count, rest zero
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0] src_fmt_q;
	logic [3:0] dst_fmt_q;
	logic       cfg_wr;
	item_t      front_item;
	item_t      queue_item;
	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;

	// register file: word select is paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_R8G8B8;
			dst_fmt_q <= FMT_R8G8B8;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SRC_FMT: src_fmt_q <= pwdata[3:0];
				default:     dst_fmt_q <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SRC_FMT: prdata = {28'd0, src_fmt_q};
			default:     prdata = {28'd0, dst_fmt_q};
		endcase
	end

	// front: channel extraction per source format
	pfc_front u_front (
		.source_format (src_fmt_q),
		.src_pixel     (s_tdata),
		.last_pixel    (s_tlast),
		.item          (front_item)
	);

	// accept whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	pfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (queue_item)
	);

	// back: insertion into destination layout, registered output
	pfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.dest_format (dst_fmt_q),
		.item_valid  (!q_empty),
		.item        (queue_item),
		.item_pop    (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule
